// ----- src/weighted_logrank_statistic_assert.svh -----
// assertion macros for the weighted log-rank statistic block
`ifndef WEIGHTED_LOGRANK_STATISTIC_ASSERT_SVH
`define WEIGHTED_LOGRANK_STATISTIC_ASSERT_SVH
// same-cycle implication, sampled on clk, off during reset
`define WLS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wls assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define WLS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wls assertion failed");
`endif

// ----- src/wls_pkg.sv -----
// shared constants, codes and types of the weighted log-rank statistic block
package wls_pkg;
	localparam int TIME_W = 32;
	localparam int WEIGHT_W = 16;
	localparam int STAT_W = 32;
	localparam int SUM_W = 28;
	localparam int WIDE_W = 48;
	localparam int SHARE_W = 17;
	localparam int SHARE_FRAC = 16;
	localparam int WEIGHT_FRAC_BITS_DEF = 8;
	localparam int STAT_FRAC_BITS_DEF = 16;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_SHARE_START, OP_SHARE_TAKE, OP_EXPECT, OP_QMUL,
		OP_Q_START, OP_Q_TAKE, OP_PQ, OP_MUL_LO, OP_MUL_HI, OP_VAR_ADD,
		OP_TIE_CLEAR, OP_UPDATE, OP_DEV, OP_SQ0, OP_SQ1, OP_SQ2, OP_SQ3,
		OP_STAT_START, OP_RESULT
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHECK, ST_SH_START, ST_SH_WAIT, ST_SH_TAKE, ST_EXP, ST_QMUL,
		ST_Q_START, ST_Q_WAIT, ST_Q_TAKE, ST_PQ, ST_MLO, ST_MHI, ST_VADD, ST_TIE,
		ST_UPDATE, ST_FIN, ST_DEV, ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_ST_START,
		ST_ST_WAIT, ST_EMIT
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic time_change;
		logic n_zero;
		logic n_gt_one;
		logic v_zero;
		logic last;
		logic div_done;
		logic out_free;
	} status_t;
endpackage

// ----- src/wls_div.sv -----
// shared restoring divider, one quotient bit per cycle
module wls_div #(
	parameter int NW = 120,
	parameter int DW = 80
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [NW-1:0]            num,
	input  logic [DW-1:0]            den,
	input  logic [$clog2(NW+1)-1:0]  nbits,
	output logic                     busy,
	output logic [NW-1:0]            quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   rem_sh;
	logic          fits;

	// remainder stays below the divisor, so one extra bit holds the shifted value
	assign rem_sh = {rem_q[DW-1:0], num_q[NW-1]};
	assign fits = rem_sh >= {1'b0, den_q};
	assign busy = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= nbits;
		end else if (busy) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo   <= '0;
		end else if (busy) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			quo   <= {quo[NW-2:0], fits};
		end
	end
endmodule

// ----- src/wls_datapath.sv -----
// accumulators, multiplier steps, divider and result register
module wls_datapath #(
	parameter int WEIGHT_FRAC_BITS = wls_pkg::WEIGHT_FRAC_BITS_DEF,
	parameter int STAT_FRAC_BITS = wls_pkg::STAT_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wls_pkg::cmd_t                 cmd,
	output wls_pkg::status_t              status,
	input  logic [wls_pkg::TIME_W-1:0]    event_time,
	input  logic                          event_status,
	input  logic                          in_group,
	input  logic [wls_pkg::WEIGHT_W-1:0]  weight,
	input  logic                          last_row,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wls_pkg::STAT_W-1:0]    statistic,
	output logic                          variance_zero,
	output logic                          stat_saturated
);
	import wls_pkg::*;

	localparam int NUM_W = 2 * WIDE_W + STAT_FRAC_BITS;
	localparam int DEN_W = WIDE_W + WEIGHT_FRAC_BITS + SHARE_FRAC;
	localparam int CW = $clog2(NUM_W + 1);
	localparam int SH_NUM_W = SUM_W + SHARE_FRAC;
	localparam int Q_W = 2 * SUM_W;
	localparam int PQ_W = 32;
	localparam int PROD_W = Q_W + PQ_W;
	localparam int HALF = WIDE_W / 2;
	localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << WEIGHT_FRAC_BITS;
	localparam logic [SHARE_W-1:0] SHARE_ONE = SHARE_W'(1) << SHARE_FRAC;

	function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	function automatic logic [WIDE_W-1:0] sat_wide(logic [WIDE_W-1:0] a, logic [WIDE_W-1:0] b);
		logic [WIDE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WIDE_W] ? {WIDE_W{1'b1}} : s[WIDE_W-1:0];
	endfunction

	logic [TIME_W-1:0]   t_q, prev_q;
	logic                st_q, grp_q, last_q, open_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [SUM_W-1:0]    risk_q, grisk_q, tie_q, obs_q;
	logic [WIDE_W-1:0]   exp_q, var_q, dev_q;
	logic [SHARE_W-1:0]  share_q;
	logic [Q_W-1:0]      q_q;
	logic [PQ_W-1:0]     pq_q;
	logic [PROD_W-1:0]   prod_q;
	logic [2*WIDE_W-1:0] sq_q;

	logic                div_start, div_busy;
	logic [NUM_W-1:0]    div_num, div_quo;
	logic [DEN_W-1:0]    div_den;
	logic [CW-1:0]       div_nbits;
	logic [SUM_W-1:0]    w_ext, nd, n_m1;
	logic [SHARE_W-1:0]  quo_share;
	logic [WIDE_W-1:0]   obs_wide, term;
	logic [HALF-1:0]     dev_hi, dev_lo;

	assign w_ext = SUM_W'(w_q);
	assign nd = (tie_q > risk_q) ? '0 : risk_q - tie_q;
	assign n_m1 = risk_q - ONE;
	assign quo_share = (div_quo[SH_NUM_W-1:0] > SH_NUM_W'(SHARE_ONE)) ? SHARE_ONE
		: div_quo[SHARE_W-1:0];
	assign obs_wide = WIDE_W'({obs_q, {SHARE_FRAC{1'b0}}});
	assign term = (prod_q[PROD_W-1:64] != '0) ? {WIDE_W{1'b1}} : prod_q[63:16];
	assign dev_hi = dev_q[WIDE_W-1:HALF];
	assign dev_lo = dev_q[HALF-1:0];

	// divider operand selection, operands aligned to the top of the register
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		div_nbits = '0;
		case (cmd.op)
			OP_SHARE_START: begin
				// zero risk keeps the share at zero without a division
				div_start = risk_q != '0;
				div_num   = {grisk_q, {SHARE_FRAC{1'b0}}, {(NUM_W-SH_NUM_W){1'b0}}};
				div_den   = DEN_W'(risk_q);
				div_nbits = CW'(SH_NUM_W);
			end
			OP_Q_START: begin
				div_start = 1'b1;
				div_num   = {q_q, {(NUM_W-Q_W){1'b0}}};
				div_den   = DEN_W'(n_m1);
				div_nbits = CW'(Q_W);
			end
			OP_STAT_START: begin
				div_start = 1'b1;
				div_num   = {sq_q, {STAT_FRAC_BITS{1'b0}}};
				div_den   = {var_q, {(WEIGHT_FRAC_BITS+SHARE_FRAC){1'b0}}};
				div_nbits = CW'(NUM_W);
			end
			default: begin
			end
		endcase
	end

	wls_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.nbits (div_nbits),
		.busy  (div_busy),
		.quo   (div_quo)
	);

	assign status.time_change = open_q && (t_q != prev_q);
	assign status.n_zero      = risk_q == '0;
	assign status.n_gt_one    = risk_q > ONE;
	assign status.v_zero      = var_q == '0;
	assign status.last        = last_q;
	assign status.div_done    = !div_busy;
	assign status.out_free    = !out_valid || out_ready;

	// control state: sums, open flag, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			risk_q    <= '0;
			grisk_q   <= '0;
			tie_q     <= '0;
			obs_q     <= '0;
			exp_q     <= '0;
			var_q     <= '0;
			prev_q    <= '0;
			open_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.op == OP_RESULT) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (cmd.op)
				OP_EXPECT:    exp_q <= sat_wide(exp_q, WIDE_W'(tie_q * share_q));
				OP_VAR_ADD:   var_q <= sat_wide(var_q, term);
				OP_TIE_CLEAR: tie_q <= '0;
				OP_UPDATE: begin
					risk_q  <= sat_sum(risk_q, w_ext);
					tie_q   <= sat_sum(tie_q, st_q ? w_ext : '0);
					grisk_q <= sat_sum(grisk_q, grp_q ? w_ext : '0);
					obs_q   <= sat_sum(obs_q, (st_q && grp_q) ? w_ext : '0);
					prev_q  <= t_q;
					open_q  <= 1'b1;
				end
				OP_RESULT: begin
					risk_q    <= '0;
					grisk_q   <= '0;
					tie_q     <= '0;
					obs_q     <= '0;
					exp_q     <= '0;
					var_q     <= '0;
					prev_q    <= '0;
					open_q    <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// payload and work registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				t_q    <= event_time;
				st_q   <= event_status;
				grp_q  <= in_group;
				w_q    <= weight;
				last_q <= last_row;
			end
			OP_SHARE_START: share_q <= '0;
			OP_SHARE_TAKE:  share_q <= quo_share;
			OP_QMUL:        q_q <= tie_q * nd;
			OP_Q_TAKE:      q_q <= div_quo[Q_W-1:0];
			OP_PQ:          pq_q <= PQ_W'(share_q * (SHARE_ONE - share_q));
			OP_MUL_LO:      prod_q <= PROD_W'(q_q[SUM_W-1:0] * pq_q);
			OP_MUL_HI:      prod_q <= prod_q + (PROD_W'(q_q[Q_W-1:SUM_W] * pq_q) << SUM_W);
			OP_DEV:         dev_q <= (exp_q >= obs_wide) ? exp_q - obs_wide : obs_wide - exp_q;
			OP_SQ0:         sq_q <= (2*WIDE_W)'(dev_lo * dev_lo);
			OP_SQ1:         sq_q <= sq_q + ((2*WIDE_W)'(dev_hi * dev_lo) << HALF);
			OP_SQ2:         sq_q <= sq_q + ((2*WIDE_W)'(dev_hi * dev_lo) << HALF);
			OP_SQ3:         sq_q <= sq_q + ((2*WIDE_W)'(dev_hi * dev_hi) << WIDE_W);
			OP_RESULT: begin
				if (var_q == '0) begin
					statistic      <= '0;
					variance_zero  <= 1'b1;
					stat_saturated <= 1'b0;
				end else if (div_quo[NUM_W-1:STAT_W] != '0) begin
					statistic      <= {STAT_W{1'b1}};
					variance_zero  <= 1'b0;
					stat_saturated <= 1'b1;
				end else begin
					statistic      <= div_quo[STAT_W-1:0];
					variance_zero  <= 1'b0;
					stat_saturated <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

// ----- src/wls_ctrl.sv -----
// sequencer for row update, tie-group close and final statistic
module wls_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wls_pkg::status_t  status,
	output wls_pkg::cmd_t     cmd
);
	import wls_pkg::*;

	state_t state_q, state_d;
	logic   final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_UPDATE && status.last) begin
				final_q <= 1'b1;
			end else if (state_q == ST_EMIT && status.out_free) begin
				final_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_CHECK;
			ST_CHECK:    state_d = status.time_change ? ST_SH_START : ST_UPDATE;
			ST_SH_START: state_d = status.n_zero ? ST_EXP : ST_SH_WAIT;
			ST_SH_WAIT:  if (status.div_done) state_d = ST_SH_TAKE;
			ST_SH_TAKE:  state_d = ST_EXP;
			ST_EXP:      state_d = status.n_gt_one ? ST_QMUL : ST_TIE;
			ST_QMUL:     state_d = ST_Q_START;
			ST_Q_START:  state_d = ST_Q_WAIT;
			ST_Q_WAIT:   if (status.div_done) state_d = ST_Q_TAKE;
			ST_Q_TAKE:   state_d = ST_PQ;
			ST_PQ:       state_d = ST_MLO;
			ST_MLO:      state_d = ST_MHI;
			ST_MHI:      state_d = ST_VADD;
			ST_VADD:     state_d = ST_TIE;
			ST_TIE:      state_d = final_q ? ST_FIN : ST_UPDATE;
			ST_UPDATE:   state_d = status.last ? ST_SH_START : ST_IDLE;
			ST_FIN:      state_d = status.v_zero ? ST_EMIT : ST_DEV;
			ST_DEV:      state_d = ST_SQ0;
			ST_SQ0:      state_d = ST_SQ1;
			ST_SQ1:      state_d = ST_SQ2;
			ST_SQ2:      state_d = ST_SQ3;
			ST_SQ3:      state_d = ST_ST_START;
			ST_ST_START: state_d = ST_ST_WAIT;
			ST_ST_WAIT:  if (status.div_done) state_d = ST_EMIT;
			ST_EMIT:     if (status.out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			// share starts at zero, the divider only runs for nonzero risk
			ST_SH_START: cmd.op = OP_SHARE_START;
			ST_SH_TAKE:  cmd.op = OP_SHARE_TAKE;
			ST_EXP:      cmd.op = OP_EXPECT;
			ST_QMUL:     cmd.op = OP_QMUL;
			ST_Q_START:  cmd.op = OP_Q_START;
			ST_Q_TAKE:   cmd.op = OP_Q_TAKE;
			ST_PQ:       cmd.op = OP_PQ;
			ST_MLO:      cmd.op = OP_MUL_LO;
			ST_MHI:      cmd.op = OP_MUL_HI;
			ST_VADD:     cmd.op = OP_VAR_ADD;
			ST_TIE:      cmd.op = OP_TIE_CLEAR;
			ST_UPDATE:   cmd.op = OP_UPDATE;
			ST_DEV:      cmd.op = OP_DEV;
			ST_SQ0:      cmd.op = OP_SQ0;
			ST_SQ1:      cmd.op = OP_SQ1;
			ST_SQ2:      cmd.op = OP_SQ2;
			ST_SQ3:      cmd.op = OP_SQ3;
			ST_ST_START: cmd.op = OP_STAT_START;
			ST_EMIT:     if (status.out_free) cmd.op = OP_RESULT;
			default: begin
			end
		endcase
	end
endmodule

// ----- src/weighted_logrank_statistic.sv -----
// top level of the two-group weighted log-rank statistic block
// usage:
//   rows stream in on the s_ side, one beat per row, in descending time order;
//   s_tlast marks the final row of a data set
//   one result beat leaves on the m_ side per data set, after its last row
// sequence:
//   a row with no time change passes through the check and update states
//   a row that closes a tie group first runs a 44-bit share division through
//   the one shared shift-subtract divider, skipped at zero risk, and when risk
//   is above one a 56-bit variance division through that divider as well
//   the last row closes its group and then runs a 112-bit division (96 plus
//   STAT_FRAC_BITS bits) for the statistic, which is skipped when the
//   variance is zero
// reset:
//   arst_n clears all sums, the open flag and the result valid; the block
//   is ready for a row as soon as reset is released
// stall:
//   a result waits in the output register while m_tready is low; the block
//   keeps taking rows, and only holds before writing the next result
module weighted_logrank_statistic #(
	parameter int WEIGHT_FRAC_BITS = wls_pkg::WEIGHT_FRAC_BITS_DEF,
	parameter int STAT_FRAC_BITS = wls_pkg::STAT_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// event_time[31:0], event_status[32], in_group[33], weight[49:34], zero[55:50]
	input  logic [55:0] s_tdata,
	// last_row
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// statistic[31:0]
	output logic [31:0] m_tdata,
	// variance_zero[0], stat_saturated[1]
	output logic [1:0]  m_tuser
);
	import wls_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer: one state per datapath step
	wls_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	// sums, multiplier steps, shared divider and output register
	wls_datapath #(
		.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
		.STAT_FRAC_BITS  (STAT_FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.event_time    (s_tdata[31:0]),
		.event_status  (s_tdata[32]),
		.in_group      (s_tdata[33]),
		.weight        (s_tdata[49:34]),
		.last_row      (s_tlast),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.statistic     (m_tdata),
		.variance_zero (m_tuser[0]),
		.stat_saturated(m_tuser[1])
	);
endmodule

// ----- src/wls_checker.sv -----
// port-level checks of the weighted log-rank statistic block, bound to the top
`include "weighted_logrank_statistic_assert.svh"
module wls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [55:0] s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);
	// a held result keeps its payload
	`WLS_ASSERT_NXT(a_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
	// zero variance gives a zero, unsaturated statistic
	`WLS_ASSERT_IMP(a_vzero, m_tvalid && m_tuser[0], m_tdata == 32'd0 && !m_tuser[1])
	// saturation clips to all ones
	`WLS_ASSERT_IMP(a_sat, m_tvalid && m_tuser[1], m_tdata == 32'hFFFF_FFFF)
	// after a row beat the block drops s_tready
	`WLS_ASSERT_NXT(a_busy, s_tvalid && s_tready, !s_tready)
endmodule

bind weighted_logrank_statistic wls_checker u_wls_checker (.*);

// ----- tb/weighted_logrank_statistic_tb.sv -----
// self-checking testbench for the weighted log-rank statistic block
module weighted_logrank_statistic_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WFRAC = wls_pkg::WEIGHT_FRAC_BITS_DEF;
	localparam int SFRAC = wls_pkg::STAT_FRAC_BITS_DEF;
	localparam logic [63:0] SUM_CAP = 64'h0FFF_FFFF;
	localparam logic [63:0] WIDE_CAP = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] SHARE_UNIT = 64'd65536;
	// cycles with no beat on either side before the run is called hung
	localparam int STALL_LIMIT = 40000;
	localparam int HOLD_CYCLES = 3000;

	// one survival row as the sender holds it
	typedef struct packed {
		logic        last;
		logic [15:0] weight;
		logic        in_group;
		logic        status;
		logic [31:0] tkey;
	} row_t;

	// one expected result beat
	typedef struct packed {
		logic [31:0] stat;
		logic        vzero;
		logic        sat;
	} stat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	row_t  row_queue[$];
	stat_t stat_queue[$];

	// running sums of the statistic, mirrored from the block's behavior
	logic [63:0] risk_acc, grp_risk_acc, tie_ev_acc, obs_acc;
	logic [63:0] exp_acc, var_acc;
	logic [31:0] prev_key;
	logic        set_open;

	int errors = 0;
	int results_seen = 0;
	int sets_sent = 0;
	int sat_seen = 0;
	int vz_seen = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 0;
	int quiet_cycles = 0;

	weighted_logrank_statistic dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	function automatic logic [63:0] add_cap(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, cap}) ? cap : s[63:0];
	endfunction

	// close the current tie group: expected and variance terms
	task automatic close_ties();
		logic [63:0]  share, nd, q, pq, one;
		logic [127:0] prod, term;
		one = 64'd1 << WFRAC;
		share = 0;
		if (risk_acc != 0) begin
			share = (grp_risk_acc << 16) / risk_acc;
			if (share > SHARE_UNIT) share = SHARE_UNIT;
		end
		exp_acc = add_cap(exp_acc, tie_ev_acc * share, WIDE_CAP);
		if (risk_acc > one) begin
			nd = (tie_ev_acc > risk_acc) ? 64'd0 : risk_acc - tie_ev_acc;
			q = (tie_ev_acc * nd) / (risk_acc - one);
			pq = share * (SHARE_UNIT - share);
			term = 0;
			if (pq != 0) begin
				prod = {64'd0, q} * {64'd0, pq};
				// a product beyond 64 bits counts as a saturated term
				if (prod > {64'd0, 64'hFFFF_FFFF_FFFF_FFFF}) term = {64'd0, WIDE_CAP};
				else term = prod >> 16;
			end
			var_acc = add_cap(var_acc, term[63:0], WIDE_CAP);
		end
		tie_ev_acc = 0;
	endtask

	// fold one accepted row into the sums, queue a result on the last row
	task automatic predict_row(row_t r);
		logic [63:0]  w, obs_w, dev;
		logic [127:0] num, den;
		stat_t res;
		w = {48'd0, r.weight};
		if (set_open && r.tkey != prev_key) close_ties();
		risk_acc = add_cap(risk_acc, w, SUM_CAP);
		if (r.status) tie_ev_acc = add_cap(tie_ev_acc, w, SUM_CAP);
		if (r.in_group) grp_risk_acc = add_cap(grp_risk_acc, w, SUM_CAP);
		if (r.status && r.in_group) obs_acc = add_cap(obs_acc, w, SUM_CAP);
		prev_key = r.tkey;
		set_open = 1;
		if (r.last) begin
			close_ties();
			res = '0;
			if (var_acc == 0) begin
				res.vzero = 1;
			end else begin
				obs_w = obs_acc << 16;
				dev = (exp_acc >= obs_w) ? exp_acc - obs_w : obs_w - exp_acc;
				num = ({64'd0, dev} * {64'd0, dev}) << SFRAC;
				den = {64'd0, var_acc} << (WFRAC + 16);
				if (num >= (den << 32)) begin
					res.stat = '1;
					res.sat = 1;
				end else begin
					res.stat = 32'(num / den);
				end
			end
			stat_queue = {stat_queue, res};
			risk_acc = 0; grp_risk_acc = 0; tie_ev_acc = 0; obs_acc = 0;
			exp_acc = 0; var_acc = 0; prev_key = 0; set_open = 0;
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
	endtask

	// driver: sample acceptance on the rising edge, change inputs on the falling edge
	bit row_taken;
	always @(posedge clk) begin
		row_taken = 0;
		if (arst_n && s_tvalid && s_tready) begin
			predict_row(row_t'({s_tlast, s_tdata[49:0]}));
			row_taken = 1;
		end
	end

	always @(negedge clk) begin
		row_t r;
		if (!arst_n) begin
			s_tvalid = 0;
		end else if (!s_tvalid || row_taken) begin
			if (row_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				r = row_queue.pop_front();
				s_tdata = {6'd0, r.weight, r.in_group, r.status, r.tkey};
				s_tlast = r.last;
				s_tvalid = 1;
			end else begin
				s_tvalid = 0;
			end
		end
	end

	// monitor: check each result beat against the oldest expectation
	int hold_count = 0;
	always @(posedge clk) begin
		stat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (stat_queue.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 32'd0);
			end else begin
				want = stat_queue.pop_front();
				if (m_tdata !== want.stat) report_mismatch("statistic", m_tdata, want.stat);
				if (m_tuser[0] !== want.vzero)
					report_mismatch("variance_zero", {31'd0, m_tuser[0]}, {31'd0, want.vzero});
				if (m_tuser[1] !== want.sat)
					report_mismatch("stat_saturated", {31'd0, m_tuser[1]}, {31'd0, want.sat});
				if (want.sat) sat_seen++;
				if (want.vzero) vz_seen++;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready = 0;
		end else if (hold_req && hold_count < HOLD_CYCLES) begin
			// long back-pressure stretch so the block fills and stops taking rows
			hold_count++;
			m_tready = 0;
		end else begin
			m_tready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on beats of either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic queue_row(logic [31:0] k, bit st, bit g, logic [15:0] w, bit last);
		row_t r;
		r.tkey = k; r.status = st; r.in_group = g; r.weight = w; r.last = last;
		row_queue = {row_queue, r};
		if (last) sets_sent++;
	endtask

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1023));
			default: return 16'($urandom);
		endcase
	endfunction

	// one data set with random rows, ties about half the time
	task automatic queue_random_set(int rows);
		logic [31:0] k;
		k = $urandom;
		for (int i = 0; i < rows; i++) begin
			if (i != 0 && $urandom_range(1) == 0) k = $urandom;
			queue_row(k, 1'($urandom_range(1)), 1'($urandom_range(1)), pick_weight(),
				i == rows - 1);
		end
	endtask

	// let everything queued drain and every result arrive
	task automatic drain();
		while (row_queue.size() != 0 || s_tvalid || stat_queue.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic random_phase(int n_rows);
		int sent;
		sent = 0;
		while (sent < n_rows) begin
			int len;
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			queue_random_set(len);
			sent += len;
		end
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tlast = 0;
		m_tready = 0;
		risk_acc = 0; grp_risk_acc = 0; tie_ev_acc = 0; obs_acc = 0;
		exp_acc = 0; var_acc = 0; prev_key = 0; set_open = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_idle_pct = 25; recv_idle_pct = 68;

		// directed: risk of exactly one, so the variance stays zero
		queue_row(32'd0, 1'b1, 1'b1, 16'h0100, 1'b1);
		// zero weight, zero risk at close
		queue_row(32'hFFFF_FFFF, 1'b1, 1'b0, 16'h0000, 1'b1);
		// extreme weights across two distinct times
		queue_row(32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 1'b0);
		queue_row(32'h0000_0000, 1'b1, 1'b0, 16'hFFFF, 1'b1);
		// a tie group of three, then a censored row
		queue_row(32'd500, 1'b1, 1'b1, 16'h0200, 1'b0);
		queue_row(32'd500, 1'b1, 1'b0, 16'h0180, 1'b0);
		queue_row(32'd500, 1'b0, 1'b1, 16'h0080, 1'b0);
		queue_row(32'd400, 1'b0, 1'b0, 16'h0300, 1'b1);
		// lopsided groups aimed at a huge statistic
		queue_row(32'd10, 1'b1, 1'b1, 16'h0001, 1'b0);
		queue_row(32'd10, 1'b0, 1'b0, 16'hFFFF, 1'b0);
		queue_row(32'd5, 1'b1, 1'b1, 16'hFFFF, 1'b0);
		queue_row(32'd4, 1'b1, 1'b1, 16'hFFFF, 1'b1);
		// all in one group: share of one, variance term zero
		queue_row(32'd7, 1'b1, 1'b1, 16'h0400, 1'b0);
		queue_row(32'd6, 1'b1, 1'b1, 16'h0400, 1'b1);
		// balanced events at three times
		queue_row(32'd9, 1'b1, 1'b1, 16'h0100, 1'b0);
		queue_row(32'd9, 1'b1, 1'b0, 16'h0100, 1'b0);
		queue_row(32'd8, 1'b1, 1'b0, 16'h0100, 1'b0);
		queue_row(32'd8, 1'b0, 1'b1, 16'h0100, 1'b0);
		queue_row(32'd3, 1'b1, 1'b1, 16'h0100, 1'b1);
		drain();

		// one long tie group of heavy rows: large sums and wide products
		for (int i = 0; i < 600; i++)
			queue_row(32'h1234_5678, i[0], i[1], 16'hFFFF, 1'b0);
		queue_row(32'h1234_5677, 1'b1, 1'b1, 16'hFFFF, 1'b1);
		drain();

		random_phase(250);
		drain();

		send_idle_pct = 68; recv_idle_pct = 25;
		random_phase(250);
		drain();

		// receiver holds off while the sender keeps offering sets
		send_idle_pct = 0; recv_idle_pct = 0;
		hold_req = 1;
		random_phase(150);
		drain();

		random_phase(380);
		drain();

		$display("covered %0d data sets and %0d result beats", sets_sent, results_seen);
		$display("%0d saturated and %0d zero-variance results, three idle mixes",
			sat_seen, vz_seen);
		if (errors == 0 && stat_queue.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
